// File: src/shhm_pkg.sv
// Shared types and constants for the snapshot history health monitor.
// Used by the top and shhm_cmp; depends on nothing.
package shhm_pkg;

    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AUTO_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAP     = 1'd1;

    localparam logic [15:0] AUTO_INTERVAL_RST = 16'd100;
    localparam logic [15:0] FORCE_GAP_RST     = 16'd10;

    localparam logic [2:0] MODE_AUTO     = 3'd0;
    localparam logic [2:0] MODE_FORCED   = 3'd1;
    localparam logic [2:0] MODE_COMMIT   = 3'd2;
    localparam logic [2:0] MODE_CHECK    = 3'd3;
    localparam logic [2:0] MODE_ROLLBACK = 3'd4;

    // health check thresholds; the drop thresholds in 18-bit signed arithmetic
    localparam logic signed [17:0] DROP_MARGIN     = 18'sd30;
    localparam logic signed [17:0] DROP_FLOOR      = -18'sd20;
    localparam logic signed [17:0] NEG_DROP_MARGIN = 18'sd10;
    localparam logic [7:0]         SPIKE_MIN       = 8'd3;

    localparam logic signed [15:0] BEST_INIT = -16'sd9999;

    localparam logic [9:0] BACKOFF_START = 10'd50;
    localparam logic [9:0] BACKOFF_MAX   = 10'd800;

    localparam int unsigned IN_DATA_W  = 96;
    localparam int unsigned IN_USER_W  = 3;
    localparam int unsigned OUT_DATA_W = 168;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP,
        ST_SAVE,
        ST_RD_NEW,
        ST_CHECK,
        ST_SCAN,
        ST_RD_TICK,
        ST_RESTORE,
        ST_FINISH
    } state_t;

    // control of the shared best-drive compare unit
    typedef struct packed {
        logic init;
        logic en;
    } scan_ctrl_t;

endpackage

// File: src/snapshot_history_health_monitor_top.sv
// Top level; depends on shhm_pkg, shhm_ring and shhm_cmp. One request at a time.
// Steps: auto and forced check the save gap, then save if it is met; commit saves;
// health check reads the newest record, checks it and scans for the best slot if degraded
// (skipped with under two records); rollback scans, reads the best slot's tick and restores.
// All end in finish. m_tvalid rises with s_tready; a result still waiting in the output register holds finish.
// aresetn: synchronous, active low; clears counters and pointers, config to defaults.
module snapshot_history_health_monitor_top #(
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tick[63:0], drive[79:64], stress[87:80], crc_ok[88], zero fill
    input  logic [shhm_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode[2:0]
    input  logic [shhm_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accepted[0], slot[4:1], degraded[5], drop amount[21:6], spike flag[22],
    // crc_fail[23], rollback tick[55:24], commit_count[87:56],
    // restore_count[119:88], commit_backoff[129:120], commit_tick[161:130]
    output logic [shhm_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [shhm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [shhm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned IW = $clog2(HISTORY_DEPTH);
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
    localparam int unsigned SW = (IW > 4) ? IW : 4;

    shhm_pkg::state_t state_reg, state_next;

    // request
    logic [2:0]         mode_reg;
    logic [63:0]        tick_reg;
    logic signed [15:0] drive_reg;
    logic [7:0]         stress_reg;
    logic               crc_ok_reg;

    // history and statistics
    logic [IW-1:0] wp_reg, wp_next;
    logic [CW-1:0] held_reg, held_next;
    logic [63:0]   last_save_reg, last_save_next;
    logic [31:0]   commits_reg, commits_next;
    logic [31:0]   restores_reg, restores_next;
    logic [9:0]    backoff_reg, backoff_next;
    logic [31:0]   last_commit_reg, last_commit_next;
    logic [31:0]   last_restore_reg, last_restore_next;
    logic [15:0]   auto_int_reg, force_gap_reg;

    // per-request result
    logic          acc_reg, acc_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic          degr_reg, degr_next;
    logic [15:0]   drop_reg, drop_next;
    logic          spike_reg, spike_next;
    logic          crcf_reg, crcf_next;

    // scan
    logic [CW-1:0] scan_i_reg, scan_i_next;
    logic          pend_reg, pend_next;
    logic [IW-1:0] pend_idx_reg;

    logic                          m_tvalid_reg;
    logic [shhm_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                          out_load;

    // memory and compare unit hookup
    logic               wr_en;
    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic signed [15:0] rd_drive;
    logic [7:0]         rd_stress;
    logic [31:0]        rd_tick;
    shhm_pkg::scan_ctrl_t scan_ctrl;
    logic [IW-1:0]      lead_slot;

    logic          in_xfer;
    logic [IW-1:0] newest;
    logic [SW-1:0] slot_ext;

    assign in_xfer  = s_tvalid && s_tready;
    assign s_tready = (state_reg == shhm_pkg::ST_IDLE);
    assign newest   = (wp_reg == '0) ? IW'(HISTORY_DEPTH - 1) : wp_reg - 1'b1;

    shhm_ring #(
        .DEPTH (HISTORY_DEPTH),
        .IW    (IW)
    ) u_ring (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wp_reg),
        .wr_drive  (drive_reg),
        .wr_stress (stress_reg),
        .wr_tick   (tick_reg[31:0]),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_drive  (rd_drive),
        .rd_stress (rd_stress),
        .rd_tick   (rd_tick)
    );

    shhm_cmp #(
        .IW (IW)
    ) u_cmp (
        .aclk      (aclk),
        .ctrl      (scan_ctrl),
        .idx       (pend_idx_reg),
        .drive     (rd_drive),
        .lead_slot (lead_slot)
    );

    always_comb begin
        logic [63:0]        gap;
        logic [15:0]        lim;
        logic signed [17:0] d;
        logic signed [17:0] ld;
        logic signed [17:0] diff;
        logic               cond_drop;
        logic               cond_neg;
        logic               cond_spike;
        logic               issue;

        state_next        = state_reg;
        wp_next           = wp_reg;
        held_next         = held_reg;
        last_save_next    = last_save_reg;
        commits_next      = commits_reg;
        restores_next     = restores_reg;
        backoff_next      = backoff_reg;
        last_commit_next  = last_commit_reg;
        last_restore_next = last_restore_reg;
        acc_next          = acc_reg;
        slot_next         = slot_reg;
        degr_next         = degr_reg;
        drop_next         = drop_reg;
        spike_next        = spike_reg;
        crcf_next         = crcf_reg;
        scan_i_next       = scan_i_reg;
        pend_next         = 1'b0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = newest;
        scan_ctrl.init    = 1'b0;
        scan_ctrl.en      = 1'b0;
        out_load          = 1'b0;

        gap  = tick_reg - last_save_reg;
        lim  = (mode_reg == shhm_pkg::MODE_AUTO) ? auto_int_reg : force_gap_reg;
        d    = 18'(drive_reg);
        ld   = 18'(rd_drive);
        diff = ld - d;
        cond_drop  = (d < ld - shhm_pkg::DROP_MARGIN) && (d < shhm_pkg::DROP_FLOOR);
        cond_neg   = (d < 0) && (ld < 0) && (d < ld - shhm_pkg::NEG_DROP_MARGIN);
        cond_spike = ({1'b0, stress_reg} > ({1'b0, rd_stress} + 9'd1))
                     && (stress_reg >= shhm_pkg::SPIKE_MIN);
        issue = scan_i_reg < held_reg;

        case (state_reg)
            shhm_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    acc_next    = 1'b0;
                    slot_next   = '0;
                    degr_next   = 1'b0;
                    drop_next   = '0;
                    spike_next  = 1'b0;
                    crcf_next   = 1'b0;
                    scan_i_next = '0;
                    case (s_tuser)
                        shhm_pkg::MODE_AUTO,
                        shhm_pkg::MODE_FORCED: state_next = shhm_pkg::ST_GAP;
                        shhm_pkg::MODE_COMMIT: state_next = shhm_pkg::ST_SAVE;
                        shhm_pkg::MODE_CHECK: begin
                            state_next = (held_reg >= CW'(2)) ? shhm_pkg::ST_RD_NEW
                                                              : shhm_pkg::ST_FINISH;
                        end
                        shhm_pkg::MODE_ROLLBACK: begin
                            if (held_reg != '0) begin
                                scan_ctrl.init = 1'b1;
                                state_next     = shhm_pkg::ST_SCAN;
                            end else begin
                                state_next = shhm_pkg::ST_FINISH;
                            end
                        end
                        default: state_next = shhm_pkg::ST_FINISH;
                    endcase
                end
            end
            shhm_pkg::ST_GAP: begin
                state_next = (gap >= 64'(lim)) ? shhm_pkg::ST_SAVE : shhm_pkg::ST_FINISH;
            end
            shhm_pkg::ST_SAVE: begin
                wr_en          = 1'b1;
                acc_next       = 1'b1;
                slot_next      = wp_reg;
                wp_next        = (wp_reg == IW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                held_next      = (held_reg != CW'(HISTORY_DEPTH)) ? held_reg + 1'b1 : held_reg;
                last_save_next = tick_reg;
                if (mode_reg == shhm_pkg::MODE_COMMIT) begin
                    commits_next     = commits_reg + 32'd1;
                    last_commit_next = tick_reg[31:0];
                    if (backoff_reg == '0) begin
                        backoff_next = shhm_pkg::BACKOFF_START;
                    end else if (backoff_reg < shhm_pkg::BACKOFF_MAX) begin
                        backoff_next = {backoff_reg[8:0], 1'b0};
                    end
                end
                state_next = shhm_pkg::ST_FINISH;
            end
            shhm_pkg::ST_RD_NEW: begin
                rd_en      = 1'b1;
                rd_addr    = newest;
                state_next = shhm_pkg::ST_CHECK;
            end
            shhm_pkg::ST_CHECK: begin
                if (cond_drop || cond_neg) begin
                    drop_next = diff[15:0];
                end
                spike_next = cond_spike;
                crcf_next  = !crc_ok_reg;
                degr_next  = cond_drop || cond_neg || cond_spike || !crc_ok_reg;
                if (cond_drop || cond_neg || cond_spike || !crc_ok_reg) begin
                    scan_ctrl.init = 1'b1;
                    state_next     = shhm_pkg::ST_SCAN;
                end else begin
                    state_next = shhm_pkg::ST_FINISH;
                end
            end
            shhm_pkg::ST_SCAN: begin
                // read issue and compare overlap: data of slot i is compared
                // in the cycle after its read is issued
                rd_addr      = scan_i_reg[IW-1:0];
                rd_en        = issue;
                pend_next    = issue;
                scan_ctrl.en = pend_reg;
                if (issue) begin
                    scan_i_next = scan_i_reg + 1'b1;
                end
                if (!issue && !pend_reg) begin
                    slot_next  = lead_slot;
                    state_next = (mode_reg == shhm_pkg::MODE_ROLLBACK) ? shhm_pkg::ST_RD_TICK
                                                                       : shhm_pkg::ST_FINISH;
                end
            end
            shhm_pkg::ST_RD_TICK: begin
                rd_en      = 1'b1;
                rd_addr    = slot_reg;
                state_next = shhm_pkg::ST_RESTORE;
            end
            shhm_pkg::ST_RESTORE: begin
                last_restore_next = rd_tick;
                restores_next     = restores_reg + 32'd1;
                acc_next          = 1'b1;
                state_next        = shhm_pkg::ST_FINISH;
            end
            shhm_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = shhm_pkg::ST_IDLE;
                end
            end
            default: state_next = shhm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= shhm_pkg::ST_IDLE;
            wp_reg           <= '0;
            held_reg         <= '0;
            last_save_reg    <= '0;
            commits_reg      <= '0;
            restores_reg     <= '0;
            backoff_reg      <= '0;
            last_commit_reg  <= '0;
            last_restore_reg <= '0;
            scan_i_reg       <= '0;
            pend_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            auto_int_reg     <= shhm_pkg::AUTO_INTERVAL_RST;
            force_gap_reg    <= shhm_pkg::FORCE_GAP_RST;
        end else begin
            state_reg        <= state_next;
            wp_reg           <= wp_next;
            held_reg         <= held_next;
            last_save_reg    <= last_save_next;
            commits_reg      <= commits_next;
            restores_reg     <= restores_next;
            backoff_reg      <= backoff_next;
            last_commit_reg  <= last_commit_next;
            last_restore_reg <= last_restore_next;
            scan_i_reg       <= scan_i_next;
            pend_reg         <= pend_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en && (cfg_index == shhm_pkg::REG_AUTO_INTERVAL)) begin
                auto_int_reg <= cfg_data;
            end
            if (cfg_wr_en && (cfg_index == shhm_pkg::REG_FORCE_GAP)) begin
                force_gap_reg <= cfg_data;
            end
        end
    end

    assign slot_ext = SW'(slot_reg);

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            mode_reg   <= s_tuser;
            tick_reg   <= s_tdata[63:0];
            drive_reg  <= s_tdata[79:64];
            stress_reg <= s_tdata[87:80];
            crc_ok_reg <= s_tdata[88];
        end
        acc_reg      <= acc_next;
        slot_reg     <= slot_next;
        degr_reg     <= degr_next;
        drop_reg     <= drop_next;
        spike_reg    <= spike_next;
        crcf_reg     <= crcf_next;
        pend_idx_reg <= scan_i_reg[IW-1:0];
        if (out_load) begin
            m_tdata_reg <= {6'd0, last_commit_reg, backoff_reg, restores_reg, commits_reg,
                            last_restore_reg, crcf_reg, spike_reg, drop_reg, degr_reg,
                            slot_ext[3:0], acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CW'(HISTORY_DEPTH))
        else $error("history count beyond depth");

    a_save_moves_wp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == shhm_pkg::ST_SAVE) |=> (wp_reg != $past(wp_reg)))
        else $error("save did not advance write pointer");

    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == shhm_pkg::ST_FINISH))
        else $error("result presented outside finish");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == shhm_pkg::ST_SCAN) |-> (scan_i_reg <= held_reg))
        else $error("scan index past held records");

endmodule

// File: src/shhm_ring.sv
// Checkpoint record memory: drive, stress and low tick word per slot.
// One write port, one registered read port. Depends on nothing.
module shhm_ring #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IW    = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [IW-1:0]       wr_addr,
    input  logic signed [15:0]  wr_drive,
    input  logic [7:0]          wr_stress,
    input  logic [31:0]         wr_tick,
    input  logic                rd_en,
    input  logic [IW-1:0]       rd_addr,
    output logic signed [15:0]  rd_drive,
    output logic [7:0]          rd_stress,
    output logic [31:0]         rd_tick
);

    logic [55:0] mem [DEPTH];
    logic [55:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_tick, wr_stress, wr_drive};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_drive  = rd_data_reg[15:0];
    assign rd_stress = rd_data_reg[23:16];
    assign rd_tick   = rd_data_reg[55:24];

endmodule

// File: src/shhm_cmp.sv
// Shared best-drive compare unit, fed one record per cycle by the sequencer.
// Depends on shhm_pkg.
module shhm_cmp #(
    parameter int unsigned IW = 4
) (
    input  logic                    aclk,
    input  shhm_pkg::scan_ctrl_t    ctrl,
    input  logic [IW-1:0]           idx,
    input  logic signed [15:0]      drive,
    output logic [IW-1:0]           lead_slot
);

    logic signed [15:0] best_reg;
    logic [IW-1:0]      lead_slot_reg;

    // strictly greater only: ties keep the lower slot
    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            best_reg      <= shhm_pkg::BEST_INIT;
            lead_slot_reg <= '0;
        end else if (ctrl.en && (drive > best_reg)) begin
            best_reg      <= drive;
            lead_slot_reg <= idx;
        end
    end

    assign lead_slot = lead_slot_reg;

endmodule
